@@ rtl/ulmc_pkg.sv @@
// Shared types, constants and functions of the UTF-8 Latin mark composer.
package ulmc_pkg;

  localparam logic [7:0] MARK_LEAD_LO = 8'hCC;  // lead byte of U+0300..U+033F
  localparam logic [7:0] MARK_LEAD_HI = 8'hCD;  // lead byte of U+0340..U+037F
  localparam int         N_SLOTS      = 4;
  localparam int         N_OPS        = 3;
  localparam logic [3:0] MARK_BLOCK   = 4'hC;   // mark[9:6] of U+0300..U+033F

  // One codepoint in UTF-8 form.
  typedef struct packed {
    logic [2:0]        len;
    logic [3:0][7:0]   b;
  } enc_t;

  // The result beats of one input byte.
  typedef struct packed {
    logic [3:0][7:0]   bytes;
    logic [1:0]        last_idx;
    logic              end_flag;
    logic              marker;   // empty end-of-string beat
  } grp_t;

  function automatic logic is_letter(logic [20:0] c);
    logic up;
    logic lo;
    up = (c >= 21'h41) && (c <= 21'h5A);
    lo = (c >= 21'h61) && (c <= 21'h7A);
    return up || lo;
  endfunction

  // Shortest UTF-8 form; raw copies one byte as is.
  function automatic enc_t utf8_encode(logic [20:0] cp, logic raw);
    enc_t e;
    e = '0;
    if (raw) begin
      e.len  = 3'd1;
      e.b[0] = cp[7:0];
    end else if (cp < 21'h80) begin
      e.len  = 3'd1;
      e.b[0] = {1'b0, cp[6:0]};
    end else if (cp < 21'h800) begin
      e.len  = 3'd2;
      e.b[0] = {3'b110, cp[10:6]};
      e.b[1] = {2'b10, cp[5:0]};
    end else if (cp < 21'h10000) begin
      e.len  = 3'd3;
      e.b[0] = {4'b1110, cp[15:12]};
      e.b[1] = {2'b10, cp[11:6]};
      e.b[2] = {2'b10, cp[5:0]};
    end else begin
      e.len  = 3'd4;
      e.b[0] = {5'b11110, cp[20:18]};
      e.b[1] = {2'b10, cp[17:12]};
      e.b[2] = {2'b10, cp[11:6]};
      e.b[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  // Precomposed form of letter + mark, 0 if none. Table and case rule kept as specified.
  function automatic logic [15:0] compose_form(logic [6:0] letter, logic [9:0] mark);
    logic        up;
    logic [6:0]  lo;
    logic [15:0] form;
    up   = (letter >= 7'h41) && (letter <= 7'h5A);
    lo   = up ? letter + 7'h20 : letter;
    form = 16'h0000;
    if (mark[9:6] == MARK_BLOCK) begin
      case ({lo, mark[5:0]})
        {7'h61, 6'h00}: form = 16'h00E0;  {7'h61, 6'h01}: form = 16'h00E1;
        {7'h61, 6'h02}: form = 16'h00E2;  {7'h61, 6'h03}: form = 16'h00E3;
        {7'h61, 6'h04}: form = 16'h0101;  {7'h61, 6'h06}: form = 16'h0103;
        {7'h61, 6'h07}: form = 16'h0227;  {7'h61, 6'h08}: form = 16'h00E4;
        {7'h61, 6'h0A}: form = 16'h00E5;  {7'h61, 6'h27}: form = 16'h00E7;
        {7'h61, 6'h28}: form = 16'h0105;
        {7'h65, 6'h00}: form = 16'h00E8;  {7'h65, 6'h01}: form = 16'h00E9;
        {7'h65, 6'h02}: form = 16'h00EA;  {7'h65, 6'h03}: form = 16'h1EB9;
        {7'h65, 6'h04}: form = 16'h0113;  {7'h65, 6'h06}: form = 16'h0115;
        {7'h65, 6'h07}: form = 16'h0117;  {7'h65, 6'h08}: form = 16'h00EB;
        {7'h65, 6'h0A}: form = 16'h1EBD;
        {7'h69, 6'h00}: form = 16'h00EC;  {7'h69, 6'h01}: form = 16'h00ED;
        {7'h69, 6'h02}: form = 16'h00EE;  {7'h69, 6'h03}: form = 16'h1ECB;
        {7'h69, 6'h04}: form = 16'h012B;  {7'h69, 6'h06}: form = 16'h012D;
        {7'h69, 6'h07}: form = 16'h1E2F;  {7'h69, 6'h08}: form = 16'h00EF;
        {7'h6F, 6'h00}: form = 16'h00F2;  {7'h6F, 6'h01}: form = 16'h00F3;
        {7'h6F, 6'h02}: form = 16'h00F4;  {7'h6F, 6'h03}: form = 16'h00F5;
        {7'h6F, 6'h04}: form = 16'h014D;  {7'h6F, 6'h06}: form = 16'h014F;
        {7'h6F, 6'h08}: form = 16'h00F6;  {7'h6F, 6'h0A}: form = 16'h00F8;
        {7'h6F, 6'h28}: form = 16'h01EB;
        {7'h75, 6'h00}: form = 16'h00F9;  {7'h75, 6'h01}: form = 16'h00FA;
        {7'h75, 6'h02}: form = 16'h00FB;  {7'h75, 6'h03}: form = 16'h1EE5;
        {7'h75, 6'h04}: form = 16'h016B;  {7'h75, 6'h06}: form = 16'h016D;
        {7'h75, 6'h08}: form = 16'h00FC;  {7'h75, 6'h0A}: form = 16'h016F;
        {7'h75, 6'h28}: form = 16'h0173;
        {7'h79, 6'h00}: form = 16'h1EF2;  {7'h79, 6'h01}: form = 16'h00FD;
        {7'h79, 6'h02}: form = 16'h1EF4;  {7'h79, 6'h03}: form = 16'h1EF8;
        {7'h79, 6'h04}: form = 16'h0233;  {7'h79, 6'h08}: form = 16'h00FF;
        {7'h63, 6'h07}: form = 16'h010B;  {7'h63, 6'h27}: form = 16'h00E7;
        {7'h67, 6'h07}: form = 16'h0121;
        {7'h6E, 6'h03}: form = 16'h00F1;  {7'h6E, 6'h28}: form = 16'h0149;
        {7'h73, 6'h27}: form = 16'h015F;
        {7'h7A, 6'h07}: form = 16'h017C;
        default:        form = 16'h0000;
      endcase
    end
    if (form != 16'h0000 && up) begin
      if (form >= 16'h00E0 && form <= 16'h00FE && form != 16'h00F7) begin
        form = form - 16'h0020;
      end else if (form >= 16'h0101 && form <= 16'h01FF && form[0]) begin
        form = form - 16'h0001;
      end
    end
    return form;
  endfunction

endpackage

@@ rtl/ulmc_step.sv @@
// Per-byte decode, compose and re-encode step with the stream state registers.
module ulmc_step (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fire,
  input  logic [7:0]         byte_in,
  input  logic               end_in,
  input  logic [15:0]        cap,
  output ulmc_pkg::grp_t     grp,
  output logic               grp_nonempty
);
  import ulmc_pkg::*;

  logic [6:0]  held_r, held_nxt;
  logic        lh_r, lh_nxt;        // letter held
  logic [20:0] pc_r, pc_nxt;        // partial codepoint / held mark lead
  logic [1:0]  bl_r, bl_nxt;        // continuation bytes left
  logic        mh_r, mh_nxt;        // mark lead held
  logic [15:0] wr_r, wr_nxt;        // bytes written

  logic [N_OPS-1:0]         op_en;
  logic [N_OPS-1:0]         op_raw;
  logic [N_OPS-1:0][20:0]   op_cp;

  logic [15:0] comp;
  logic [20:0] cont_cp;
  logic [1:0]  bl_dec;
  logic [1:0]  slot;

  logic [16:0]       w;
  logic [2:0]        pos;
  logic [2:0]        sp;
  enc_t              e;
  logic [3:0][7:0]   slots;

  // Next state and the list of codepoints to emit, in order.
  always_comb begin
    held_nxt = held_r;
    lh_nxt   = lh_r;
    pc_nxt   = pc_r;
    bl_nxt   = bl_r;
    mh_nxt   = mh_r;
    op_en    = '0;
    op_raw   = '0;
    op_cp    = '0;
    comp     = compose_form(held_r, {pc_r[3:0], byte_in[5:0]});
    cont_cp  = {pc_r[14:0], byte_in[5:0]};
    bl_dec   = bl_r - 2'd1;
    slot     = {1'b0, lh_r};

    if (mh_r) begin
      mh_nxt = 1'b0;
      lh_nxt = 1'b0;
      pc_nxt = '0;
      if (comp != 16'h0000) begin
        op_en[0] = 1'b1;
        op_cp[0] = {5'b0, comp};
      end else begin
        op_en[0] = 1'b1;
        op_cp[0] = {14'b0, held_r};
        op_en[1] = 1'b1;
        op_cp[1] = {10'b0, pc_r[4:0], byte_in[5:0]};
      end
    end else if (bl_r != 2'd0) begin
      bl_nxt = bl_dec;
      if (bl_dec == 2'd0) begin
        pc_nxt = '0;
        if (is_letter(cont_cp)) begin
          held_nxt = cont_cp[6:0];
          lh_nxt   = 1'b1;
        end else begin
          op_en[0] = 1'b1;
          op_cp[0] = cont_cp;
        end
      end else begin
        pc_nxt = cont_cp;
      end
    end else if (lh_r && (byte_in == MARK_LEAD_LO || byte_in == MARK_LEAD_HI)) begin
      mh_nxt = 1'b1;
      pc_nxt = {13'b0, byte_in};
    end else begin
      if (lh_r) begin
        lh_nxt   = 1'b0;
        op_en[0] = 1'b1;
        op_cp[0] = {14'b0, held_r};
      end
      if (!byte_in[7]) begin
        if (is_letter({13'b0, byte_in})) begin
          held_nxt = byte_in[6:0];
          lh_nxt   = 1'b1;
        end else begin
          op_en[slot] = 1'b1;
          op_cp[slot] = {13'b0, byte_in};
        end
      end else if (byte_in[7:5] == 3'b110) begin
        pc_nxt = {16'b0, byte_in[4:0]};
        bl_nxt = 2'd1;
      end else if (byte_in[7:4] == 4'b1110) begin
        pc_nxt = {17'b0, byte_in[3:0]};
        bl_nxt = 2'd2;
      end else if (byte_in[7:3] == 5'b11110) begin
        pc_nxt = {18'b0, byte_in[2:0]};
        bl_nxt = 2'd3;
      end else begin
        op_en[slot]  = 1'b1;
        op_raw[slot] = 1'b1;
        op_cp[slot]  = {13'b0, byte_in};
      end
    end

    // string end flushes a held letter
    if (end_in && lh_nxt) begin
      op_en[2] = 1'b1;
      op_cp[2] = {14'b0, held_nxt};
    end
  end

  // Capacity check per codepoint and packing of the bytes into beat slots.
  always_comb begin
    w     = {1'b0, wr_r};
    pos   = 3'd0;
    slots = '0;
    sp    = 3'd0;
    e     = '0;
    for (int k = 0; k < N_OPS; k++) begin
      e = utf8_encode(op_cp[k], op_raw[k]);
      if (op_en[k] && (w + {14'b0, e.len} < {1'b0, cap})) begin
        for (int j = 0; j < N_SLOTS; j++) begin
          sp = pos + 3'(j);
          if (3'(j) < e.len && !sp[2]) begin
            slots[sp[1:0]] = e.b[j];
          end
        end
        w   = w + {14'b0, e.len};
        pos = pos + e.len;
      end
    end
    wr_nxt = end_in ? 16'd0 : w[15:0];

    grp.bytes    = slots;
    grp.last_idx = (pos == 3'd0) ? 2'd0 : 2'(pos - 3'd1);
    grp.end_flag = end_in;
    grp.marker   = (pos == 3'd0);
    grp_nonempty = (pos != 3'd0) || end_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      lh_r   <= 1'b0;
      pc_r   <= '0;
      bl_r   <= '0;
      mh_r   <= 1'b0;
      wr_r   <= '0;
    end else if (fire) begin
      if (end_in) begin
        held_r <= '0;
        lh_r   <= 1'b0;
        pc_r   <= '0;
        bl_r   <= '0;
        mh_r   <= 1'b0;
      end else begin
        held_r <= held_nxt;
        lh_r   <= lh_nxt;
        pc_r   <= pc_nxt;
        bl_r   <= bl_nxt;
        mh_r   <= mh_nxt;
      end
      wr_r <= wr_nxt;
    end
  end

endmodule

@@ rtl/ulmc_serializer.sv @@
// Result register that plays out one byte group as single-byte beats.
module ulmc_serializer (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             load,
  input  ulmc_pkg::grp_t   grp,
  output logic             ready,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,   // out_byte
  output logic             out_tuser,   // out_valid
  output logic             out_tlast    // out_last
);
  import ulmc_pkg::*;

  grp_t       grp_r;
  logic       v_r;
  logic [1:0] idx_r;
  logic       last_beat;

  always_comb begin
    last_beat  = (idx_r == grp_r.last_idx);
    ready      = !v_r || (out_tready && last_beat);
    out_tvalid = v_r;
    out_tdata  = grp_r.bytes[idx_r];
    out_tuser  = !grp_r.marker;
    out_tlast  = grp_r.end_flag && last_beat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r   <= 1'b0;
      idx_r <= '0;
    end else if (load) begin
      v_r   <= 1'b1;
      idx_r <= '0;
    end else if (v_r && out_tready) begin
      if (last_beat) begin
        v_r <= 1'b0;
      end else begin
        idx_r <= idx_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      grp_r <= grp;
    end
  end

endmodule

@@ rtl/utf8_latin_mark_composer.sv @@
// Top level of the UTF-8 Latin mark composer: input register, config register, step, output.
//
// Takes one UTF-8 byte per beat on in_ and gives cleaned UTF-8 on out_, one byte per beat.
// Each accepted byte runs through one registered pass: an input register, the decode/compose/
// re-encode step (state updated in the same cycle), and a result register holding the zero to
// four bytes that byte produced. A byte is taken every cycle as long as each byte yields at most
// one output beat and out_tready is high; a byte that yields more beats holds the input side
// until its last beat is taken, since the output port moves one byte a beat.
// A held ASCII letter waits for the next codepoint, so a letter's byte appears only after the
// following byte (or with the end of string). in_tlast ends a string: a held letter is flushed,
// the last beat carries out_tlast, and a string end that produces no byte gives one beat with
// out_tuser low and out_tdata zero. The byte count against out_capacity restarts after each
// string end. out_capacity (address 0) should only be written while the block is idle.
module utf8_latin_mark_composer (
  input  logic        clk,
  input  logic        rst_n,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // in_byte
  input  logic        in_tlast,    // end_of_string
  // result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // out_byte
  output logic        out_tuser,   // out_valid
  output logic        out_tlast,   // out_last
  // register port
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import ulmc_pkg::*;

  logic        in_v_r;
  logic [7:0]  in_byte_r;
  logic        in_end_r;
  logic [15:0] cap_r;

  logic        grp_ready;
  logic        fire;
  grp_t        grp;
  logic        grp_nonempty;
  logic        cfg_wr;

  // a stored byte moves on when the result register can take its beats
  assign fire      = in_v_r && grp_ready;
  assign in_tready = !in_v_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      in_v_r <= 1'b1;
    end else if (fire) begin
      in_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_byte_r <= in_tdata;
      in_end_r  <= in_tlast;
    end
  end

  // register port: out_capacity at byte address 0
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = cfg_paddr[2] ? 32'd0 : {16'd0, cap_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= 16'hFFFF;
    end else if (cfg_wr && !cfg_paddr[2]) begin
      cap_r <= cfg_pwdata[15:0];
    end
  end

  ulmc_step u_step (
    .clk          (clk),
    .rst_n        (rst_n),
    .fire         (fire),
    .byte_in      (in_byte_r),
    .end_in       (in_end_r),
    .cap          (cap_r),
    .grp          (grp),
    .grp_nonempty (grp_nonempty)
  );

  ulmc_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (fire && grp_nonempty),
    .grp        (grp),
    .ready      (grp_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
